// File: design/ppt_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_pkg
// Shared sizes, command codes and control structs of the process priority
// table.
// ----------------------------------------------------------------------------
package ppt_pkg;

  localparam int unsigned SLOTS = 16;
  localparam int unsigned IdxW  = (SLOTS > 1) ? $clog2(SLOTS) : 1;
  localparam int unsigned IdW   = 16;
  localparam int unsigned PriW  = 8;
  localparam int unsigned CmdW  = 2;

  // Code 3 is unused: it changes nothing and returns an all-zero result.
  typedef enum logic [CmdW-1:0] {
    CMD_ADD    = 2'd0,
    CMD_REMOVE = 2'd1,
    CMD_QUERY  = 2'd2
  } cmd_e;

  // Sequencer to scan unit.
  typedef struct packed {
    logic            init;
    logic            step;
    logic [CmdW-1:0] cmd;
  } scan_ctrl_t;

  // Scan unit state seen by the sequencer.
  typedef struct packed {
    logic            hit;
    logic            have;
    logic            free_found;
    logic [IdxW-1:0] free_idx;
    logic [IdW-1:0]  best_id;
    logic [PriW-1:0] best_pri;
  } scan_res_t;

endpackage : ppt_pkg
`default_nettype wire

// File: design/process_priority_table_unit.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// process_priority_table_unit
// Table of SLOTS process slots with add, remove by id and most-urgent query.
// Sequence: ST_SCAN compares one slot per step across the table, ST_DONE writes
//   back an added entry and forms the result, and done_o is registered from ST_DONE.
// Items: a new item is taken only while busy_o is low, so none is accepted before
//   the single slot compare unit has walked the table; busy_o is high meanwhile.
// Reset: asynchronous, clears all valid bits; the table is usable at once.
// The result is shown for one cycle on done_o and cannot be stalled.
// ----------------------------------------------------------------------------
module process_priority_table_unit (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic                       start_i,
  output logic                            busy_o,
  input  wire logic [ppt_pkg::CmdW-1:0]   command_i,
  input  wire logic [ppt_pkg::IdW-1:0]    proc_id_i,
  input  wire logic [ppt_pkg::PriW-1:0]   proc_priority_i,
  output logic                            done_o,
  output logic                            ok_o,
  output logic [ppt_pkg::IdW-1:0]         out_id_o,
  output logic [ppt_pkg::PriW-1:0]        out_priority_o
);
  import ppt_pkg::*;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_SCAN = 3'b010,
    ST_DONE = 3'b100
  } state_e;

  state_e          state_q, state_d;
  logic [IdxW-1:0] idx_q, idx_d;
  logic [CmdW-1:0] cmd_q;
  logic [IdW-1:0]  id_q;
  logic [PriW-1:0] pri_q;
  logic            done_q, done_d;
  logic            ok_q, ok_d;
  logic [IdW-1:0]  out_id_q, out_id_d;
  logic [PriW-1:0] out_pri_q, out_pri_d;

  scan_ctrl_t      ctrl;
  scan_res_t       res;
  logic            slot_valid;
  logic [IdW-1:0]  slot_id;
  logic [PriW-1:0] slot_pri;
  logic            wr_en;
  logic            last;

  assign last  = (idx_q == IdxW'(SLOTS - 1));
  assign wr_en = (state_q == ST_DONE) && (cmd_q == CMD_ADD) && res.free_found;

  always_comb begin
    state_d   = state_q;
    idx_d     = idx_q;
    ctrl      = '0;
    ctrl.cmd  = cmd_q;
    done_d    = 1'b0;
    ok_d      = ok_q;
    out_id_d  = out_id_q;
    out_pri_d = out_pri_q;
    unique case (state_q)
      ST_IDLE: begin
        if (start_i) begin
          state_d   = ST_SCAN;
          idx_d     = '0;
          ctrl.init = 1'b1;
        end
      end
      ST_SCAN: begin
        ctrl.step = 1'b1;
        if (last) begin
          state_d = ST_DONE;
        end else begin
          idx_d = idx_q + IdxW'(1);
        end
      end
      ST_DONE: begin
        state_d   = ST_IDLE;
        done_d    = 1'b1;
        ok_d      = 1'b0;
        out_id_d  = '0;
        out_pri_d = '0;
        if (cmd_q == CMD_ADD) begin
          ok_d = res.free_found;
        end else if (cmd_q == CMD_REMOVE) begin
          ok_d = res.have;
        end else if (cmd_q == CMD_QUERY) begin
          ok_d = res.have;
          if (res.have) begin
            out_id_d  = res.best_id;
            out_pri_d = res.best_pri;
          end
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= ST_IDLE;
      idx_q   <= '0;
      done_q  <= 1'b0;
    end else begin
      state_q <= state_d;
      idx_q   <= idx_d;
      done_q  <= done_d;
    end
  end

  // Hold the item for the whole walk.
  always_ff @(posedge clk_i) begin
    if ((state_q == ST_IDLE) && start_i) begin
      cmd_q <= command_i;
      id_q  <= proc_id_i;
      pri_q <= proc_priority_i;
    end
    ok_q      <= ok_d;
    out_id_q  <= out_id_d;
    out_pri_q <= out_pri_d;
  end

  ppt_store u_store (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .rd_idx_i   (idx_q),
    .clr_i      (res.hit),
    .wr_en_i    (wr_en),
    .wr_idx_i   (res.free_idx),
    .wr_id_i    (id_q),
    .wr_pri_i   (pri_q),
    .rd_valid_o (slot_valid),
    .rd_id_o    (slot_id),
    .rd_pri_o   (slot_pri)
  );

  ppt_scan u_scan (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .ctrl_i       (ctrl),
    .proc_id_i    (id_q),
    .idx_i        (idx_q),
    .slot_valid_i (slot_valid),
    .slot_id_i    (slot_id),
    .slot_pri_i   (slot_pri),
    .res_o        (res)
  );

  assign busy_o         = (state_q != ST_IDLE);
  assign done_o         = done_q;
  assign ok_o           = ok_q;
  assign out_id_o       = out_id_q;
  assign out_priority_o = out_pri_q;

endmodule : process_priority_table_unit
`default_nettype wire

// File: design/ppt_store.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_store
// Slot store: valid bits cleared at reset, id and priority per slot, one
// read/clear address and one write address.
// ----------------------------------------------------------------------------
module ppt_store (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire logic [ppt_pkg::IdxW-1:0]   rd_idx_i,
  input  wire logic                       clr_i,
  input  wire logic                       wr_en_i,
  input  wire logic [ppt_pkg::IdxW-1:0]   wr_idx_i,
  input  wire logic [ppt_pkg::IdW-1:0]    wr_id_i,
  input  wire logic [ppt_pkg::PriW-1:0]   wr_pri_i,
  output logic                            rd_valid_o,
  output logic [ppt_pkg::IdW-1:0]         rd_id_o,
  output logic [ppt_pkg::PriW-1:0]        rd_pri_o
);
  import ppt_pkg::*;

  logic [SLOTS-1:0] valid_q, valid_d;
  logic [IdW-1:0]   id_q  [SLOTS];
  logic [PriW-1:0]  pri_q [SLOTS];

  always_comb begin
    valid_d = valid_q;
    if (clr_i) begin
      valid_d[rd_idx_i] = 1'b0;
    end
    if (wr_en_i) begin
      valid_d[wr_idx_i] = 1'b1;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      valid_q <= '0;
    end else begin
      valid_q <= valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (wr_en_i) begin
      id_q[wr_idx_i]  <= wr_id_i;
      pri_q[wr_idx_i] <= wr_pri_i;
    end
  end

  assign rd_valid_o = valid_q[rd_idx_i];
  assign rd_id_o    = id_q[rd_idx_i];
  assign rd_pri_o   = pri_q[rd_idx_i];

endmodule : ppt_store
`default_nettype wire

// File: design/ppt_scan.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_scan
// Shared compare unit: looks at one slot per step, matching its id and
// ranking its priority, and keeps the running free slot, found flag and
// best entry.
// ----------------------------------------------------------------------------
module ppt_scan (
  input  wire logic                       clk_i,
  input  wire logic                       rst_ni,
  input  wire ppt_pkg::scan_ctrl_t        ctrl_i,
  input  wire logic [ppt_pkg::IdW-1:0]    proc_id_i,
  input  wire logic [ppt_pkg::IdxW-1:0]   idx_i,
  input  wire logic                       slot_valid_i,
  input  wire logic [ppt_pkg::IdW-1:0]    slot_id_i,
  input  wire logic [ppt_pkg::PriW-1:0]   slot_pri_i,
  output ppt_pkg::scan_res_t              res_o
);
  import ppt_pkg::*;

  logic            have_q, have_d;
  logic            free_found_q, free_found_d;
  logic [IdxW-1:0] free_idx_q, free_idx_d;
  logic [IdW-1:0]  best_id_q, best_id_d;
  logic [PriW-1:0] best_pri_q, best_pri_d;
  logic            match;
  logic            better;
  logic            is_add;
  logic            is_remove;
  logic            is_query;

  assign is_add    = (ctrl_i.cmd == CMD_ADD);
  assign is_remove = (ctrl_i.cmd == CMD_REMOVE);
  assign is_query  = (ctrl_i.cmd == CMD_QUERY);
  assign match     = slot_valid_i && (slot_id_i == proc_id_i);
  // Strictly smaller only, so the lowest slot keeps a tie.
  assign better    = slot_valid_i && (!have_q || (best_pri_q > slot_pri_i));

  always_comb begin
    have_d       = have_q;
    free_found_d = free_found_q;
    free_idx_d   = free_idx_q;
    best_id_d    = best_id_q;
    best_pri_d   = best_pri_q;
    if (ctrl_i.init) begin
      have_d       = 1'b0;
      free_found_d = 1'b0;
    end else if (ctrl_i.step) begin
      if (is_remove && match) begin
        have_d = 1'b1;
      end
      if (is_query && better) begin
        have_d     = 1'b1;
        best_id_d  = slot_id_i;
        best_pri_d = slot_pri_i;
      end
      // A slot freed by the id removal counts as free.
      if (is_add && !free_found_q && (!slot_valid_i || match)) begin
        free_found_d = 1'b1;
        free_idx_d   = idx_i;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      have_q       <= 1'b0;
      free_found_q <= 1'b0;
    end else begin
      have_q       <= have_d;
      free_found_q <= free_found_d;
    end
  end

  always_ff @(posedge clk_i) begin
    free_idx_q <= free_idx_d;
    best_id_q  <= best_id_d;
    best_pri_q <= best_pri_d;
  end

  always_comb begin
    res_o            = '0;
    res_o.hit        = ctrl_i.step && match && (is_add || is_remove);
    res_o.have       = have_q;
    res_o.free_found = free_found_q;
    res_o.free_idx   = free_idx_q;
    res_o.best_id    = best_id_q;
    res_o.best_pri   = best_pri_q;
  end

endmodule : ppt_scan
`default_nettype wire

// File: design/ppt_checker.sv
`timescale 1ns / 1ps
`default_nettype none
// ----------------------------------------------------------------------------
// ppt_checker
// Port-level checks of the process priority table: item timing and the
// zero fields of an unsuccessful result.
// ----------------------------------------------------------------------------
module ppt_checker (
  input wire logic                       clk_i,
  input wire logic                       rst_ni,
  input wire logic                       start_i,
  input wire logic                       busy_o,
  input wire logic                       done_o,
  input wire logic                       ok_o,
  input wire logic [ppt_pkg::IdW-1:0]    out_id_o,
  input wire logic [ppt_pkg::PriW-1:0]   out_priority_o
);
  import ppt_pkg::*;

  localparam int unsigned Latency = SLOTS + 2;

  logic accept;
  assign accept = start_i && !busy_o;

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |=> busy_o)
    else $error("busy not raised after an accepted item");

  assert property (@(posedge clk_i) disable iff (!rst_ni) accept |-> ##Latency done_o)
    else $error("result strobe missing at the expected latency");

  assert property (@(posedge clk_i) disable iff (!rst_ni) done_o |-> !busy_o)
    else $error("result strobe while still busy");

  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (done_o && !ok_o) |-> ((out_id_o == '0) && (out_priority_o == '0)))
    else $error("non-zero fields on an unsuccessful result");

endmodule : ppt_checker

bind process_priority_table_unit ppt_checker u_ppt_checker (
  .clk_i          (clk_i),
  .rst_ni         (rst_ni),
  .start_i        (start_i),
  .busy_o         (busy_o),
  .done_o         (done_o),
  .ok_o           (ok_o),
  .out_id_o       (out_id_o),
  .out_priority_o (out_priority_o)
);
`default_nettype wire
